// ===== src/mpslp_pkg.sv =====
// Shared types and constants for the motor power slew limiter with PWM output.
// Used by every module of the block; depends on nothing.
package mpslp_pkg;

    // Full-scale power and duty scaling divisor.
    localparam logic [12:0] FULL_SCALE = 13'd3200;

    // Reset values of the configuration registers.
    localparam logic [11:0] LIMIT_RESET  = 12'd3200;
    localparam logic [12:0] SLEW_RESET   = 13'd3200;
    localparam logic [15:0] PERIOD_RESET = 16'd3528;

    // Request kinds.
    localparam logic [1:0] KIND_SET = 2'd0;
    localparam logic [1:0] KIND_OFF = 2'd1;
    localparam logic [1:0] KIND_ON  = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_GLOBAL_LIMIT = 3'd0;
    localparam logic [2:0] REG_LEFT_LIMIT   = 3'd1;
    localparam logic [2:0] REG_RIGHT_LIMIT  = 3'd2;
    localparam logic [2:0] REG_SLEW_STEP    = 3'd3;
    localparam logic [2:0] REG_PWM_PERIOD   = 3'd4;

    // Division by 3200 = shift by 7, then divide by 25 through a reciprocal.
    localparam int          DIV_SHIFT   = 7;
    localparam logic [19:0] DIV25_MUL   = 20'd671088;  // floor(2^24 / 25)
    localparam int          DIV25_SHIFT = 24;
    localparam logic [20:0] DIV25       = 21'd25;

    typedef struct packed {
        logic [11:0] global_limit;
        logic [11:0] left_limit;
        logic [11:0] right_limit;
        logic [12:0] slew_step;
        logic [15:0] pwm_period;
    } cfg_t;

    // Per-request fields carried alongside the duty computation.
    typedef struct packed {
        logic               channel;
        logic signed [12:0] applied_power;
        logic               direction;
        logic               driver_enable;
    } meta_t;

    // Output of the power stage into the duty pipeline.
    typedef struct packed {
        meta_t       meta;
        logic [15:0] span;
        logic [11:0] level;
    } power_stage_t;

endpackage

// ===== src/motor_power_slew_limiter_pwm.sv =====
// Top level of the two-channel motor power slew limiter with direction-pin PWM.
// Depends on mpslp_pkg, mpslp_cfg, mpslp_power and mpslp_duty.
//
// Usage:
//   Requests enter on the s_axis channel: tuser carries the kind (set power,
//   turn off, turn on) and the channel, tdata the signed requested power.
//   Every request yields exactly one result on m_axis: the channel, its stored
//   power, the direction pin level, the PWM compare value and the bridge enable.
//   Limits, slew step and PWM period are written through the cfg_* port while
//   no request is in flight.
// Pipeline: a request accepted on s_axis passes through the input register,
//   clamp stage, multiply stage, reciprocal stage and output register, in
//   that order, before it appears on m_axis.
// Throughput: one request per cycle while m_axis_tready is high. The stored
//   powers are written by the clamp stage, so the next request sees them at once.
// Reset: both stored powers clear, the bridge is disabled, limits and slew step
//   return to 3200, the period to 3528, and the pipeline empties.
// Stall: when m_axis_tready is low the pipeline stages fill one by one;
//   s_axis_tready drops only once every stage holds a request.
module motor_power_slew_limiter_pwm
    import mpslp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] power_request
    input  logic [2:0]  s_axis_tuser,   // [1:0] kind, [2] channel

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [12:0] applied_power, [13] direction,
                                        // [29:14] duty, [30] driver_enable, [31] zero
    output logic        m_axis_tuser,   // [0] out_channel

    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t         cfg;
    logic         init_pulse;
    logic         s1_valid;
    logic         s1_ready;
    power_stage_t s1_data;
    meta_t        res_meta;
    logic [15:0]  res_duty;

    // Configuration registers; a turn-on request while inactive restores global limit and slew.
    mpslp_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .init_pulse (init_pulse),
        .cfg        (cfg)
    );

    // Hold the request, clamp it, advance the stored powers.
    mpslp_power u_power (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .kind          (s_axis_tuser[1:0]),
        .channel       (s_axis_tuser[2]),
        .power_request (s_axis_tdata),
        .cfg           (cfg),
        .init_pulse    (init_pulse),
        .s1_valid      (s1_valid),
        .s1_ready_dn   (s1_ready),
        .s1_data       (s1_data)
    );

    // Scale the level to a compare value and register the result.
    mpslp_duty u_duty (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s1_valid),
        .in_ready     (s1_ready),
        .in_data      (s1_data),
        .out_valid    (m_axis_tvalid),
        .out_ready_dn (m_axis_tready),
        .out_meta     (res_meta),
        .out_duty     (res_duty)
    );

    assign m_axis_tdata = {1'b0, res_meta.driver_enable, res_duty,
                           res_meta.direction, res_meta.applied_power};
    assign m_axis_tuser = res_meta.channel;

endmodule

// ===== src/mpslp_cfg.sv =====
// Configuration registers of the motor power slew limiter.
// Depends on mpslp_pkg; the power stage may restore defaults on a turn-on request.
module mpslp_cfg
    import mpslp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        init_pulse,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GLOBAL_LIMIT:
                begin
                    // Clamp the global limit to full scale.
                    if ({1'b0, cfg_data[11:0]} > FULL_SCALE)
                        cfg_next.global_limit = LIMIT_RESET;
                    else
                        cfg_next.global_limit = cfg_data[11:0];
                end
                REG_LEFT_LIMIT:  cfg_next.left_limit  = cfg_data[11:0];
                REG_RIGHT_LIMIT: cfg_next.right_limit = cfg_data[11:0];
                REG_SLEW_STEP:   cfg_next.slew_step   = cfg_data[12:0];
                REG_PWM_PERIOD:  cfg_next.pwm_period  = cfg_data[15:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
        if (init_pulse)
        begin
            cfg_next.global_limit = LIMIT_RESET;
            cfg_next.slew_step    = SLEW_RESET;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.global_limit <= LIMIT_RESET;
            cfg_reg.left_limit   <= LIMIT_RESET;
            cfg_reg.right_limit  <= LIMIT_RESET;
            cfg_reg.slew_step    <= SLEW_RESET;
            cfg_reg.pwm_period   <= PERIOD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/mpslp_power.sv =====
// Input register, limit and slew clamps, and the stored channel powers.
// Depends on mpslp_pkg; feeds the duty pipeline and signals turn-on to the config registers.
module mpslp_power
    import mpslp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [1:0]   kind,
    input  logic         channel,
    input  logic [15:0]  power_request,
    input  cfg_t         cfg,
    output logic         init_pulse,
    output logic         s1_valid,
    input  logic         s1_ready_dn,
    output power_stage_t s1_data
);

    logic               inq_valid_reg;
    logic [1:0]         inq_kind_reg;
    logic               inq_channel_reg;
    logic [15:0]        inq_request_reg;

    logic signed [12:0] left_power_reg,  left_power_next;
    logic signed [12:0] right_power_reg, right_power_next;
    logic               active_reg,      active_next;

    logic               s1_valid_reg;
    power_stage_t       s1_data_reg, s1_data_next;

    logic               s1_ready;
    logic               advance;

    logic signed [16:0] req_s, lo_s, hi_s, p1_s;
    logic signed [16:0] store_s, step_s, lo2_s, hi2_s, p2_s;
    logic signed [16:0] drive_s, adj_s;
    logic [11:0]        chan_limit, hi_u;
    logic signed [12:0] store;
    logic               is_set;

    assign s1_ready = !s1_valid_reg || s1_ready_dn;
    assign in_ready = !inq_valid_reg || s1_ready;
    assign advance  = inq_valid_reg && s1_ready;

    // Limit and slew clamps for a set-power request.
    always_comb
    begin
        req_s      = {inq_request_reg[15], inq_request_reg};
        chan_limit = inq_channel_reg ? cfg.right_limit : cfg.left_limit;
        hi_u       = (chan_limit < cfg.global_limit) ? chan_limit : cfg.global_limit;
        hi_s       = signed'({5'b0, hi_u});
        lo_s       = -signed'({5'b0, cfg.global_limit});

        if (req_s < lo_s)
            p1_s = lo_s;
        else if (req_s > hi_s)
            p1_s = hi_s;
        else
            p1_s = req_s;

        store   = inq_channel_reg ? right_power_reg : left_power_reg;
        store_s = {{4{store[12]}}, store};
        step_s  = signed'({4'b0, cfg.slew_step});
        lo2_s   = store_s - step_s;
        hi2_s   = store_s + step_s;

        if (p1_s < lo2_s)
            p2_s = lo2_s;
        else if (p1_s > hi2_s)
            p2_s = hi2_s;
        else
            p2_s = p1_s;

        // Right motor is mounted mirrored: invert its sign.
        drive_s = inq_channel_reg ? -p2_s : p2_s;
        adj_s   = drive_s[16] ? drive_s + signed'({4'b0, FULL_SCALE}) : drive_s;
    end

    // Next stored state per request kind.
    always_comb
    begin
        left_power_next  = left_power_reg;
        right_power_next = right_power_reg;
        active_next      = active_reg;
        is_set           = 1'b0;
        init_pulse       = 1'b0;
        unique case (inq_kind_reg)
            KIND_SET:
            begin
                is_set = 1'b1;
                if (inq_channel_reg)
                    right_power_next = p2_s[12:0];
                else
                    left_power_next = p2_s[12:0];
            end
            KIND_OFF:
            begin
                active_next      = 1'b0;
                left_power_next  = '0;
                right_power_next = '0;
            end
            KIND_ON:
            begin
                if (!active_reg)
                begin
                    active_next      = 1'b1;
                    left_power_next  = '0;
                    right_power_next = '0;
                    init_pulse       = advance;
                end
            end
            default:
            begin
                active_next = active_reg;
            end
        endcase
    end

    always_comb
    begin
        s1_data_next.meta.channel       = inq_channel_reg;
        s1_data_next.meta.applied_power = inq_channel_reg ? right_power_next
                                                          : left_power_next;
        s1_data_next.meta.direction     = is_set && drive_s[16];
        s1_data_next.meta.driver_enable = active_next;
        s1_data_next.span  = (cfg.pwm_period == 16'd0) ? 16'd0 : cfg.pwm_period - 16'd1;
        s1_data_next.level = is_set ? adj_s[11:0] : 12'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inq_valid_reg   <= 1'b0;
            s1_valid_reg    <= 1'b0;
            left_power_reg  <= '0;
            right_power_reg <= '0;
            active_reg      <= 1'b0;
        end
        else
        begin
            if (in_ready)
                inq_valid_reg <= in_valid;
            if (s1_ready)
                s1_valid_reg <= inq_valid_reg;
            if (advance)
            begin
                left_power_reg  <= left_power_next;
                right_power_reg <= right_power_next;
                active_reg      <= active_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            inq_kind_reg    <= kind;
            inq_channel_reg <= channel;
            inq_request_reg <= power_request;
        end
        if (advance)
            s1_data_reg <= s1_data_next;
    end

    assign s1_valid = s1_valid_reg;
    assign s1_data  = s1_data_reg;

endmodule

// ===== src/mpslp_duty.sv =====
// Duty scaling pipeline: span times level, then division by full scale.
// Depends on mpslp_pkg; ends in the output register of the block.
module mpslp_duty
    import mpslp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  power_stage_t in_data,
    output logic         out_valid,
    input  logic         out_ready_dn,
    output meta_t        out_meta,
    output logic [15:0]  out_duty
);

    logic        s2_valid_reg;
    meta_t       s2_meta_reg;
    logic [27:0] s2_prod_reg;

    logic        s3_valid_reg;
    meta_t       s3_meta_reg;
    logic [20:0] s3_x_reg;
    logic [15:0] s3_q_reg;

    logic        out_valid_reg;
    meta_t       out_meta_reg;
    logic [15:0] out_duty_reg;

    logic        s2_ready, s3_ready, out_ready;

    logic [27:0] prod_next;
    logic [20:0] x_next;
    logic [40:0] recip_prod;
    logic [15:0] q_next;
    logic [20:0] rem;
    logic [15:0] duty_next;

    assign out_ready = !out_valid_reg || out_ready_dn;
    assign s3_ready  = !s3_valid_reg || out_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign in_ready  = s2_ready;

    always_comb
    begin
        prod_next  = {12'b0, in_data.span} * {16'b0, in_data.level};
        x_next     = s2_prod_reg[27:DIV_SHIFT];
        recip_prod = {20'b0, x_next} * {21'b0, DIV25_MUL};
        q_next     = recip_prod[DIV25_SHIFT +: 16];
        // Estimate is low by at most one: fix with a single compare.
        rem        = s3_x_reg - 21'({5'b0, s3_q_reg} * DIV25);
        duty_next  = (rem >= DIV25) ? s3_q_reg + 16'd1 : s3_q_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_ready)
                s2_valid_reg <= in_valid;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
            if (out_ready)
                out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && in_valid)
        begin
            s2_meta_reg <= in_data.meta;
            s2_prod_reg <= prod_next;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_meta_reg <= s2_meta_reg;
            s3_x_reg    <= x_next;
            s3_q_reg    <= q_next;
        end
        if (out_ready && s3_valid_reg)
        begin
            out_meta_reg <= s3_meta_reg;
            out_duty_reg <= duty_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_meta  = out_meta_reg;
    assign out_duty  = out_duty_reg;

endmodule
